// ===== sv/lgge_pkg.sv =====
package lgge_pkg;

    // grid size defaults
    localparam int MAX_ROWS_DEF = 32;
    localparam int MAX_COLS_DEF = 32;

    // fixed field widths
    localparam int KIND_W  = 2;
    localparam int ROW_W   = 5;
    localparam int COL_W   = 5;
    localparam int CELLS_W = 32;
    localparam int CFG_W   = 6;
    localparam int CFG_IDX_W = 1;

    // holds a clamped row or column count up to 64
    localparam int GEOM_W = 7;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_ROWS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_COLS = 1'b1;
    localparam logic [CFG_W-1:0]     CFG_RESET       = 6'd32;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_TOGGLE  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADVANCE = 2'd1;

    // command queue depth
    localparam int Q_DEPTH = 2;

    typedef enum logic [1:0] {
        OP_TOGGLE,
        OP_ADVANCE,
        OP_SHOW,
        OP_ERROR
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
    } t_cmd;

    typedef struct packed {
        logic [GEOM_W-1:0] rows;
        logic [GEOM_W-1:0] cols;
    } t_geom;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADV,
        ST_ADV_END,
        ST_TGL_RD,
        ST_TGL_WR,
        ST_EMIT,
        ST_ERR
    } t_state;

endpackage

// ===== sv/lgge_front.sv =====
module lgge_front #(
    parameter int MAX_ROWS = lgge_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgge_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [lgge_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lgge_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_start,
    input  logic [lgge_pkg::KIND_W-1:0]    i_kind,
    input  logic [lgge_pkg::ROW_W-1:0]     i_row,
    input  logic [lgge_pkg::COL_W-1:0]     i_col,
    input  logic                           i_q_full,
    output logic                           o_push,
    output lgge_pkg::t_cmd                 o_cmd,
    output lgge_pkg::t_geom                o_geom
);

    localparam int GW = lgge_pkg::GEOM_W;

    logic [lgge_pkg::CFG_W-1:0] r_rows_cfg;
    logic [lgge_pkg::CFG_W-1:0] r_cols_cfg;
    logic [GW-1:0]              rows;
    logic [GW-1:0]              cols;
    logic                       out_of_grid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_cfg <= lgge_pkg::CFG_RESET;
            r_cols_cfg <= lgge_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                lgge_pkg::REG_ACTIVE_ROWS: r_rows_cfg <= i_cfg_data;
                lgge_pkg::REG_ACTIVE_COLS: r_cols_cfg <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // zero acts as one, anything above the grid acts as the grid size
    always_comb begin
        if (r_rows_cfg == '0) begin
            rows = GW'(1);
        end else if (GW'(r_rows_cfg) > GW'(MAX_ROWS)) begin
            rows = GW'(MAX_ROWS);
        end else begin
            rows = GW'(r_rows_cfg);
        end
        if (r_cols_cfg == '0) begin
            cols = GW'(1);
        end else if (GW'(r_cols_cfg) > GW'(MAX_COLS)) begin
            cols = GW'(MAX_COLS);
        end else begin
            cols = GW'(r_cols_cfg);
        end
    end

    assign out_of_grid = (GW'(i_row) >= rows) || (GW'(i_col) >= cols);

    always_comb begin
        o_cmd.row = i_row;
        o_cmd.col = i_col;
        case (i_kind)
            lgge_pkg::KIND_TOGGLE:  o_cmd.op = out_of_grid ? lgge_pkg::OP_ERROR
                                                           : lgge_pkg::OP_TOGGLE;
            lgge_pkg::KIND_ADVANCE: o_cmd.op = lgge_pkg::OP_ADVANCE;
            default:                o_cmd.op = lgge_pkg::OP_SHOW;
        endcase
    end

    assign o_push      = i_start && !i_q_full;
    assign o_geom.rows = rows;
    assign o_geom.cols = cols;

endmodule

// ===== sv/lgge_queue.sv =====
module lgge_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lgge_pkg::t_cmd i_cmd,
    input  logic           i_pop,
    output logic           o_valid,
    output logic           o_full,
    output lgge_pkg::t_cmd o_cmd
);

    localparam int PW = $clog2(lgge_pkg::Q_DEPTH);
    localparam int CW = $clog2(lgge_pkg::Q_DEPTH + 1);

    lgge_pkg::t_cmd r_slot [lgge_pkg::Q_DEPTH];
    logic [PW-1:0]  r_wr_ptr;
    logic [PW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;
    logic [PW-1:0]  n_wr_ptr;
    logic [PW-1:0]  n_rd_ptr;
    logic [CW-1:0]  n_count;
    logic           do_push;
    logic           do_pop;

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(lgge_pkg::Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(lgge_pkg::Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == CW'(lgge_pkg::Q_DEPTH));
    assign o_cmd   = r_slot[r_rd_ptr];

endmodule

// ===== sv/lgge_back.sv =====
module lgge_back #(
    parameter int MAX_ROWS = lgge_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgge_pkg::MAX_COLS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  lgge_pkg::t_geom              i_geom,
    input  logic                         i_q_valid,
    input  lgge_pkg::t_cmd               i_q_cmd,
    output logic                         o_q_pop,
    output logic                         o_strobe,
    output logic [lgge_pkg::ROW_W-1:0]   o_row_index,
    output logic [lgge_pkg::CELLS_W-1:0] o_row_cells,
    output logic                         o_last,
    output logic                         o_error
);

    localparam int RA_W = $clog2(MAX_ROWS);
    localparam int CA_W = $clog2(MAX_COLS);
    localparam int CNT_W = $clog2(MAX_ROWS + 1);
    localparam int GW = lgge_pkg::GEOM_W;

    // one generation of one row, B3/S23, dead beyond both edges
    function automatic logic [MAX_COLS-1:0] life_row(
        input logic [MAX_COLS-1:0] above,
        input logic [MAX_COLS-1:0] mid,
        input logic [MAX_COLS-1:0] below
    );
        logic [MAX_COLS+1:0] a;
        logic [MAX_COLS+1:0] m;
        logic [MAX_COLS+1:0] b;
        logic [3:0]          cnt;
        logic [MAX_COLS-1:0] res;
        a = {1'b0, above, 1'b0};
        m = {1'b0, mid, 1'b0};
        b = {1'b0, below, 1'b0};
        for (int j = 0; j < MAX_COLS; j++) begin
            cnt = 4'(a[j]) + 4'(a[j+1]) + 4'(a[j+2]) + 4'(m[j]) + 4'(m[j+2])
                + 4'(b[j]) + 4'(b[j+1]) + 4'(b[j+2]);
            res[j] = mid[j] ? ((cnt == 4'd2) || (cnt == 4'd3)) : (cnt == 4'd3);
        end
        return res;
    endfunction

    lgge_pkg::t_state r_state;
    lgge_pkg::t_state n_state;
    lgge_pkg::t_cmd   r_cmd;

    // row memory, with a valid bit per row so reset reads as dead
    logic [MAX_COLS-1:0] r_mem [MAX_ROWS];
    logic [MAX_ROWS-1:0] r_row_ok;
    logic [MAX_ROWS-1:0] n_row_ok;
    logic [MAX_COLS-1:0] r_rd_data;
    logic                r_rd_ok;

    logic [CNT_W-1:0]    r_cnt;
    logic [CNT_W-1:0]    n_cnt;

    // read stage tags
    logic                r_p1_adv;
    logic                r_p1_emit;
    logic                r_p1_pad;
    logic                r_p1_last;
    logic [CNT_W-1:0]    r_p1_idx;
    logic                n_p1_adv;
    logic                n_p1_emit;
    logic                n_p1_pad;
    logic                n_p1_last;

    // line buffers for the old contents during an advance
    logic [MAX_COLS-1:0] r_prev_old;
    logic [MAX_COLS-1:0] r_cur_old;

    logic                         r_o_strobe;
    logic [lgge_pkg::ROW_W-1:0]   r_o_row_index;
    logic [lgge_pkg::CELLS_W-1:0] r_o_row_cells;
    logic                         r_o_last;
    logic                         r_o_error;

    logic [CNT_W-1:0]    rows;
    logic [CNT_W-1:0]    rows_m1;
    logic [GW-1:0]       cols;
    logic [MAX_COLS-1:0] mask;
    logic                rd_en;
    logic [RA_W-1:0]     rd_addr;
    logic                clr_hi;
    logic                w_en;
    logic [RA_W-1:0]     w_addr;
    logic [MAX_COLS-1:0] w_data;
    logic [MAX_COLS-1:0] rd_row;
    logic [MAX_COLS-1:0] tgl_bit;

    assign rows    = CNT_W'(i_geom.rows);
    assign rows_m1 = rows - 1'b1;
    assign cols    = i_geom.cols;

    always_comb begin
        for (int j = 0; j < MAX_COLS; j++) begin
            mask[j] = (GW'(j) < cols);
        end
    end

    assign rd_row  = r_rd_ok ? (r_rd_data & mask) : '0;
    assign tgl_bit = {{(MAX_COLS-1){1'b0}}, 1'b1} << CA_W'(r_cmd.col);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            lgge_pkg::ST_IDLE: begin
                if (i_q_valid) begin
                    case (i_q_cmd.op)
                        lgge_pkg::OP_TOGGLE:  n_state = lgge_pkg::ST_TGL_RD;
                        lgge_pkg::OP_ADVANCE: n_state = lgge_pkg::ST_ADV;
                        lgge_pkg::OP_ERROR:   n_state = lgge_pkg::ST_ERR;
                        default:              n_state = lgge_pkg::ST_EMIT;
                    endcase
                end
            end
            lgge_pkg::ST_ADV: begin
                if (r_cnt == rows) begin
                    n_state = lgge_pkg::ST_ADV_END;
                end
            end
            lgge_pkg::ST_ADV_END: n_state = lgge_pkg::ST_EMIT;
            lgge_pkg::ST_TGL_RD:  n_state = lgge_pkg::ST_TGL_WR;
            lgge_pkg::ST_TGL_WR:  n_state = lgge_pkg::ST_EMIT;
            lgge_pkg::ST_EMIT: begin
                if (r_cnt == rows_m1) begin
                    n_state = lgge_pkg::ST_IDLE;
                end
            end
            lgge_pkg::ST_ERR:     n_state = lgge_pkg::ST_IDLE;
            default:              n_state = lgge_pkg::ST_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb begin
        o_q_pop   = 1'b0;
        clr_hi    = 1'b0;
        rd_en     = 1'b0;
        rd_addr   = r_cnt[RA_W-1:0];
        n_cnt     = r_cnt;
        n_p1_adv  = 1'b0;
        n_p1_emit = 1'b0;
        n_p1_pad  = 1'b0;
        n_p1_last = 1'b0;
        case (r_state)
            lgge_pkg::ST_IDLE: begin
                o_q_pop = i_q_valid;
                clr_hi  = i_q_valid && (i_q_cmd.op == lgge_pkg::OP_ADVANCE);
                n_cnt   = '0;
            end
            lgge_pkg::ST_ADV: begin
                // one extra step past the last row feeds a dead row below it
                rd_en    = (r_cnt != rows);
                n_p1_adv = 1'b1;
                n_p1_pad = (r_cnt == rows);
                n_cnt    = r_cnt + 1'b1;
            end
            lgge_pkg::ST_ADV_END: begin
                // readout starts again from row 0
                n_cnt = '0;
            end
            lgge_pkg::ST_TGL_RD: begin
                rd_en   = 1'b1;
                rd_addr = RA_W'(r_cmd.row);
            end
            lgge_pkg::ST_EMIT: begin
                rd_en     = 1'b1;
                n_p1_emit = 1'b1;
                n_p1_last = (r_cnt == rows_m1);
                n_cnt     = r_cnt + 1'b1;
            end
            default: ;
        endcase
    end

    // write port: advance writes the row above the one just read, a toggle writes its row back with one cell flipped
    always_comb begin
        w_en   = 1'b0;
        w_addr = RA_W'(r_cmd.row);
        w_data = (r_rd_ok ? r_rd_data : '0) ^ tgl_bit;
        if (r_p1_adv && (r_p1_idx != '0)) begin
            w_en   = 1'b1;
            w_addr = RA_W'(r_p1_idx - 1'b1);
            w_data = life_row(r_prev_old, r_cur_old, r_p1_pad ? '0 : rd_row) & mask;
        end else if (r_state == lgge_pkg::ST_TGL_WR) begin
            w_en = 1'b1;
        end
    end

    // rows outside the region die at an advance, written rows become valid
    always_comb begin
        n_row_ok = r_row_ok;
        if (clr_hi) begin
            for (int i = 0; i < MAX_ROWS; i++) begin
                if (CNT_W'(i) >= rows) begin
                    n_row_ok[i] = 1'b0;
                end
            end
        end
        if (w_en) begin
            n_row_ok[w_addr] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= lgge_pkg::ST_IDLE;
            r_cnt      <= '0;
            r_p1_adv   <= 1'b0;
            r_p1_emit  <= 1'b0;
            r_row_ok   <= '0;
            r_o_strobe <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_cnt      <= n_cnt;
            r_p1_adv   <= n_p1_adv;
            r_p1_emit  <= n_p1_emit;
            r_o_strobe <= r_p1_emit || (r_state == lgge_pkg::ST_ERR);
            r_row_ok   <= n_row_ok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mem[w_addr] <= w_data;
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_ok   <= r_row_ok[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
        r_p1_pad  <= n_p1_pad;
        r_p1_last <= n_p1_last;
        r_p1_idx  <= r_cnt;
        if (r_p1_adv) begin
            if (r_p1_idx == '0) begin
                r_prev_old <= '0;
            end else begin
                r_prev_old <= r_cur_old;
            end
            r_cur_old <= r_p1_pad ? '0 : rd_row;
        end
        if (r_p1_emit) begin
            r_o_row_index <= lgge_pkg::ROW_W'(r_p1_idx);
            r_o_row_cells <= lgge_pkg::CELLS_W'(rd_row);
            r_o_last      <= r_p1_last;
            r_o_error     <= 1'b0;
        end else begin
            r_o_row_index <= '0;
            r_o_row_cells <= '0;
            r_o_last      <= 1'b1;
            r_o_error     <= 1'b1;
        end
    end

    assign o_strobe    = r_o_strobe;
    assign o_row_index = r_o_row_index;
    assign o_row_cells = r_o_row_cells;
    assign o_last      = r_o_last;
    assign o_error     = r_o_error;

`ifndef SYNTHESIS
    // a rejected toggle gives one empty closing result
    a_err_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_strobe && r_o_error |-> r_o_last && (r_o_row_cells == '0))
        else $error("error result not a single empty last row");

    // rows of one request leave without gaps
    a_emit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p1_emit && !r_p1_last |=> r_p1_emit)
        else $error("row output run broken before last row");

    // advance write-back drained before rows are read out
    a_adv_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == lgge_pkg::ST_ADV_END |=> !r_p1_adv && !w_en)
        else $error("advance write-back still in flight at readout");
`endif

endmodule

// ===== sv/life_grid_generation_engine.sv =====
// a show request reads its rows straight out; an advance first writes the new generation
//   back row by row and a valid toggle first rewrites its row; a rejected toggle gives one error result
// throughput: one row result per cycle while a request's rows are read out; requests are
//   served one at a time through the one-read one-write row memory
// the receiver cannot stall: results leave on o_strobe, one cycle each
// reset (synchronous, active low) clears the grid to all dead and sets both counts to 32
module life_grid_generation_engine #(
    parameter int MAX_ROWS = lgge_pkg::MAX_ROWS_DEF,
    parameter int MAX_COLS = lgge_pkg::MAX_COLS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // configuration writes, to be made only while no request is in flight; the block does not enforce it
    input  logic                           i_cfg_we,
    input  logic [lgge_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [lgge_pkg::CFG_W-1:0]     i_cfg_data,
    // request side
    input  logic                           start,
    output logic                           busy,
    input  logic [lgge_pkg::KIND_W-1:0]    i_kind,
    input  logic [lgge_pkg::ROW_W-1:0]     i_row,
    input  logic [lgge_pkg::COL_W-1:0]     i_col,
    // result side
    output logic                           o_strobe,
    output logic [lgge_pkg::ROW_W-1:0]     o_row_index,
    output logic [lgge_pkg::CELLS_W-1:0]   o_row_cells,
    output logic                           o_last,
    output logic                           o_error
);

    // front: config registers, count clamping and request decode
    // queue: two decoded requests, so a new request lands while rows still stream out
    // back: row memory sequencer doing toggles, generations and row readout

    logic            push;
    logic            q_full;
    logic            q_valid;
    logic            q_pop;
    lgge_pkg::t_cmd  push_cmd;
    lgge_pkg::t_cmd  head_cmd;
    lgge_pkg::t_geom geom;

    lgge_front #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_start    (start),
        .i_kind     (i_kind),
        .i_row      (i_row),
        .i_col      (i_col),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_cmd      (push_cmd),
        .o_geom     (geom)
    );

    lgge_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_full  (q_full),
        .o_cmd   (head_cmd)
    );

    lgge_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_geom      (geom),
        .i_q_valid   (q_valid),
        .i_q_cmd     (head_cmd),
        .o_q_pop     (q_pop),
        .o_strobe    (o_strobe),
        .o_row_index (o_row_index),
        .o_row_cells (o_row_cells),
        .o_last      (o_last),
        .o_error     (o_error)
    );

    // new requests wait only while the queue is full
    assign busy = q_full;

endmodule
